// File: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement recency stack.
package lrupr_pkg;

  localparam int MAX_FRAMES = 512;
  localparam int KEY_W      = 40;
  localparam int POS_W      = $clog2(MAX_FRAMES);
  localparam int HPOS_W     = 9;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 10;

  // Entry moving from one cell to the next during a walk
  typedef struct packed {
    logic             act;
    logic             vld;
    logic [KEY_W-1:0] key;
  } flow_t;

  // Signals broadcast by the controller to every cell
  typedef struct packed {
    logic             kill;
    logic [KEY_W-1:0] skey;
  } bcast_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_HOLD
  } state_t;

endpackage

// File: rtl/lrupr_cell.sv
// One recency stack cell: holds a frame key and its valid bit.
module lrupr_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lrupr_pkg::bcast_t bc,
  input  lrupr_pkg::flow_t  flow_in,
  output lrupr_pkg::flow_t  flow_out,
  output logic              hit
);

  logic [lrupr_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                        vld_r, vld_nxt;
  logic                        fact_r, fact_nxt;
  logic                        fvld_r, fvld_nxt;
  logic [lrupr_pkg::KEY_W-1:0] fkey_r, fkey_nxt;
  logic                        hit_r, hit_nxt;
  logic                        match;

  // compare the stored frame only when the walk is at this cell
  assign match = flow_in.act && vld_r && (key_r == bc.skey);

  // take the incoming entry, pass the old one on unless the walk stops here
  always_comb begin
    key_nxt  = key_r;
    vld_nxt  = vld_r;
    fact_nxt = flow_in.act && !match && !bc.kill;
    fvld_nxt = vld_r;
    fkey_nxt = key_r;
    hit_nxt  = match;
    if (flow_in.act) begin
      key_nxt = flow_in.key;
      vld_nxt = flow_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    fvld_r <= fvld_nxt;
    fkey_r <= fkey_nxt;
    if (!rst_n) begin
      vld_r  <= 1'b0;
      fact_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      fact_r <= fact_nxt;
      hit_r  <= hit_nxt;
    end
  end

  assign flow_out.act = fact_r;
  assign flow_out.vld = fvld_r;
  assign flow_out.key = fkey_r;
  assign hit          = hit_r;

endmodule

// File: rtl/lrupr_chain.sv
// Row of recency stack cells linked head to tail, with the hit flag merge.
module lrupr_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  lrupr_pkg::bcast_t bc,
  input  lrupr_pkg::flow_t  inject,
  output logic              any_hit
);

  lrupr_pkg::flow_t                  flow_o [lrupr_pkg::MAX_FRAMES];
  logic [lrupr_pkg::MAX_FRAMES-1:0]  hit_vec;

  // cell 0 takes the new key, each later cell takes its neighbour's output
  for (genvar i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lrupr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .bc       (bc),
        .flow_in  (inject),
        .flow_out (flow_o[i]),
        .hit      (hit_vec[i])
      );
    end else begin : g_body
      lrupr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .bc       (bc),
        .flow_in  (flow_o[i-1]),
        .flow_out (flow_o[i]),
        .hit      (hit_vec[i])
      );
    end
  end

  // at most one cell flags a hit in any cycle
  assign any_hit = |hit_vec;

endmodule

// File: rtl/lru_page_replacement.sv
// Top level: LRU page replacement over a recency stack of page frames.
//
//  Channel | Ports                                          | Handshake
//  --------+------------------------------------------------+---------------
//  input   | in_page_key                                    | in_valid/in_ready
//  result  | out_hit, out_hit_position, out_hits_so_far,    | out_valid/out_ready
//          | out_misses_so_far                              |
//  config  | cfg_wr_data (frames in use)                    | cfg_wr_en
//
// A transfer sends the key down the cell row one cell per clock. A hit at
// position p completes once the walk reaches cell p, a miss once it has
// passed the last of the n frames in use; the walk rate sets this.
// Synchronous reset clears all valid bits, both counters and the control.
// A finished result waits in the output register while the next key is
// taken; a second result waits in a holding register until out_ready.
module lru_page_replacement (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrupr_pkg::KEY_W-1:0]      in_page_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_hit,
  output logic [lrupr_pkg::HPOS_W-1:0]     out_hit_position,
  output logic [lrupr_pkg::CNT_W-1:0]      out_hits_so_far,
  output logic [lrupr_pkg::CNT_W-1:0]      out_misses_so_far,
  input  logic                             cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wr_data
);

  lrupr_pkg::state_t            state_r, state_nxt;
  logic [lrupr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [lrupr_pkg::POS_W-1:0]  last_r, last_nxt;
  logic [lrupr_pkg::KEY_W-1:0]  skey_r, skey_nxt;
  logic                         inj_act_r, inj_act_nxt;
  logic [lrupr_pkg::CNT_W-1:0]  hits_r, hits_nxt;
  logic [lrupr_pkg::CNT_W-1:0]  misses_r, misses_nxt;
  logic                         res_hit_r, res_hit_nxt;
  logic [lrupr_pkg::POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [lrupr_pkg::HPOS_W-1:0] out_pos_r, out_pos_nxt;
  logic [lrupr_pkg::CNT_W-1:0]  out_hits_r, out_hits_nxt;
  logic [lrupr_pkg::CNT_W-1:0]  out_misses_r, out_misses_nxt;

  logic                         kill;
  logic                         dec;
  logic                         dec_hit;
  logic [lrupr_pkg::POS_W-1:0]  dec_pos;
  logic                         out_free;
  logic                         any_hit;
  lrupr_pkg::bcast_t            bc;
  lrupr_pkg::flow_t             inject;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == lrupr_pkg::ST_IDLE);

  // cell row
  assign bc.kill    = kill;
  assign bc.skey    = skey_r;
  assign inject.act = inj_act_r;
  assign inject.vld = 1'b1;
  assign inject.key = skey_r;

  lrupr_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .bc      (bc),
    .inject  (inject),
    .any_hit (any_hit)
  );

  // walk control, counters and result staging
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    skey_nxt       = skey_r;
    inj_act_nxt    = 1'b0;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    res_hit_nxt    = res_hit_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hit_nxt    = out_hit_r;
    out_pos_nxt    = out_pos_r;
    out_hits_nxt   = out_hits_r;
    out_misses_nxt = out_misses_r;
    kill           = 1'b0;
    dec            = 1'b0;
    dec_hit        = 1'b0;
    dec_pos        = '0;

    // clamp the frame count to 1..MAX_FRAMES and keep the last index
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        last_nxt = '0;
      end else if (int'(cfg_wr_data) >= lrupr_pkg::MAX_FRAMES) begin
        last_nxt = lrupr_pkg::POS_W'(lrupr_pkg::MAX_FRAMES - 1);
      end else begin
        last_nxt = lrupr_pkg::POS_W'(cfg_wr_data - 1'b1);
      end
    end

    case (state_r)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid) begin
          skey_nxt    = in_page_key;
          inj_act_nxt = 1'b1;
          pos_nxt     = '0;
          state_nxt   = lrupr_pkg::ST_WALK;
        end
      end
      lrupr_pkg::ST_WALK: begin
        pos_nxt = pos_r + 1'b1;
        if (any_hit) begin
          dec     = 1'b1;
          dec_hit = 1'b1;
          dec_pos = pos_r - 1'b1;
        end else if (pos_r == last_r) begin
          kill      = 1'b1;
          state_nxt = lrupr_pkg::ST_FIN;
        end
      end
      lrupr_pkg::ST_FIN: begin
        dec     = 1'b1;
        dec_hit = any_hit;
        dec_pos = any_hit ? last_r : '0;
      end
      lrupr_pkg::ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_pos_nxt    = lrupr_pkg::HPOS_W'(res_pos_r);
          out_hits_nxt   = hits_r;
          out_misses_nxt = misses_r;
          state_nxt      = lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrupr_pkg::ST_IDLE;
      end
    endcase

    // count the access and deliver or park the result
    if (dec) begin
      if (dec_hit) begin
        if (hits_r != '1) begin
          hits_nxt = hits_r + 1'b1;
        end
      end else begin
        if (misses_r != '1) begin
          misses_nxt = misses_r + 1'b1;
        end
      end
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_hit_nxt    = dec_hit;
        out_pos_nxt    = lrupr_pkg::HPOS_W'(dec_pos);
        out_hits_nxt   = hits_nxt;
        out_misses_nxt = misses_nxt;
        state_nxt      = lrupr_pkg::ST_IDLE;
      end else begin
        res_hit_nxt = dec_hit;
        res_pos_nxt = dec_pos;
        state_nxt   = lrupr_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    skey_r       <= skey_nxt;
    res_hit_r    <= res_hit_nxt;
    res_pos_r    <= res_pos_nxt;
    out_hit_r    <= out_hit_nxt;
    out_pos_r    <= out_pos_nxt;
    out_hits_r   <= out_hits_nxt;
    out_misses_r <= out_misses_nxt;
    if (!rst_n) begin
      state_r     <= lrupr_pkg::ST_IDLE;
      last_r      <= lrupr_pkg::POS_W'(lrupr_pkg::MAX_FRAMES - 1);
      inj_act_r   <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      inj_act_r   <= inj_act_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_hit_position  = out_pos_r;
  assign out_hits_so_far   = out_hits_r;
  assign out_misses_so_far = out_misses_r;

  // a cell only flags a hit while a walk is under way
  a_hit_in_walk : assert property (@(posedge clk) disable iff (!rst_n)
    any_hit |-> (state_r == lrupr_pkg::ST_WALK || state_r == lrupr_pkg::ST_FIN))
    else $error("hit flag outside a walk");

  // a miss reports position zero
  a_miss_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_position == '0))
    else $error("miss with nonzero position");

  // a hit lies within the frames in use
  a_hit_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_position <= lrupr_pkg::HPOS_W'(last_r)))
    else $error("hit position beyond frames in use");

  // counters never go backwards
  a_count_mono : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hits_r >= $past(hits_r) && misses_r >= $past(misses_r)))
    else $error("counter decreased");

endmodule
